// ===== sv/gim_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gim_pkg
// Shared codes and the result record of the gap interval merger.
// ----------------------------------------------------------------------------
package gim_pkg;

  // input opcodes
  localparam logic OP_INTERVAL = 1'b0;
  localparam logic OP_END      = 1'b1;

  // result kinds
  localparam logic KIND_GAP     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int FIELD_BITS = 32;
  localparam int DROP_BITS  = 2;

  // one result request as it sits in the output queue
  typedef struct packed {
    logic                  kind;
    logic [FIELD_BITS-1:0] gap_begin;
    logic [FIELD_BITS-1:0] gap_end;
    logic [FIELD_BITS-1:0] covered_length;
    logic [FIELD_BITS-1:0] island_total;
    logic [FIELD_BITS-1:0] seq_length_out;
    logic [FIELD_BITS-1:0] dropped_length;
    logic [DROP_BITS-1:0]  dropped_total;
    logic                  last;
  } res_t;

endpackage

// ===== sv/gim_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gim_front
// Accepts input requests, turns intervals into 0-based half-open form and
// holds the decoded items in a two-entry queue for the merge stage.
// ----------------------------------------------------------------------------
module gim_front #(
  parameter int COORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  opcode,
  input  logic [31:0]           ann_start,
  input  logic [31:0]           ann_stop,
  input  logic [31:0]           seq_length,
  output logic                  item_valid,
  input  logic                  item_take,
  output logic                  item_end,
  output logic [COORD_BITS-1:0] item_s,
  output logic [COORD_BITS-1:0] item_e,
  output logic [COORD_BITS-1:0] item_span,
  output logic [COORD_BITS-1:0] item_len
);

  localparam int W = COORD_BITS;

  logic [W-1:0] s_raw, e_raw, s0, e0, span0, len0;
  logic         q_end  [2];
  logic [W-1:0] q_s    [2];
  logic [W-1:0] q_e    [2];
  logic [W-1:0] q_span [2];
  logic [W-1:0] q_len  [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;
  logic         do_push, do_pop;

  // classify: 0-based start, clamp empty intervals, precompute span
  always_comb begin
    s_raw = W'(ann_start);
    e_raw = W'(ann_stop);
    s0    = (s_raw == '0) ? '0 : s_raw - W'(1);
    e0    = (e_raw < s0) ? s0 : e_raw;
    span0 = e0 - s0;
    len0  = W'(seq_length);
  end

  assign full       = (count == 2'd2);
  assign do_push    = push && !full;
  assign item_valid = (count != 2'd0);
  assign do_pop     = item_take && item_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_end[wr_ptr]  <= (opcode == gim_pkg::OP_END);
      q_s[wr_ptr]    <= s0;
      q_e[wr_ptr]    <= e0;
      q_span[wr_ptr] <= span0;
      q_len[wr_ptr]  <= len0;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  assign item_end  = q_end[rd_ptr];
  assign item_s    = q_s[rd_ptr];
  assign item_e    = q_e[rd_ptr];
  assign item_span = q_span[rd_ptr];
  assign item_len  = q_len[rd_ptr];

endmodule

// ===== sv/gim_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gim_back
// Island merge engine: extends or closes the open island, tracks sums and
// counts, and writes gap and summary requests into the output queue.
// ----------------------------------------------------------------------------
module gim_back #(
  parameter int COORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [COORD_BITS-1:0] gap,
  input  logic                  item_valid,
  output logic                  item_take,
  input  logic                  item_end,
  input  logic [COORD_BITS-1:0] item_s,
  input  logic [COORD_BITS-1:0] item_e,
  input  logic [COORD_BITS-1:0] item_span,
  input  logic [COORD_BITS-1:0] item_len,
  input  logic                  out_space,
  output logic                  res_write,
  output gim_pkg::res_t         res_data
);

  localparam int W = COORD_BITS;

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_END2 = 2'b10
  } state_t;

  state_t       state, state_next;
  logic         island_open, island_open_next;
  logic [W-1:0] open_begin, open_begin_next;
  logic [W-1:0] open_end, open_end_next;
  logic [W-1:0] island_len, island_len_next;
  logic [W-1:0] length_sum, length_sum_next;
  logic [W-1:0] island_counter, island_counter_next;
  logic [W-1:0] drop_length_sum, drop_length_sum_next;
  logic [1:0]   drop_counter, drop_counter_next;
  logic [W-1:0] tail, tail_next;
  logic         tail_drop, tail_drop_next;
  logic [W-1:0] end_len, end_len_next;

  logic         run, merge, tail_nz, drop_now;
  logic [W-1:0] tail_w;

  assign run       = (state == ST_RUN) && item_valid && out_space;
  assign item_take = run;

  // merge test against the open island
  assign merge   = island_open && ((item_s <= open_end) || ((item_s - open_end) <= gap));
  // tail gap at end of sequence
  assign tail_nz  = item_len > open_end;
  assign tail_w   = item_len - open_end;
  assign drop_now = island_open && tail_nz && (tail_w <= gap);

  always_comb begin
    state_next           = state;
    island_open_next     = island_open;
    open_begin_next      = open_begin;
    open_end_next        = open_end;
    island_len_next      = island_len;
    length_sum_next      = length_sum;
    island_counter_next  = island_counter;
    drop_length_sum_next = drop_length_sum;
    drop_counter_next    = drop_counter;
    tail_next            = tail;
    tail_drop_next       = tail_drop;
    end_len_next         = end_len;
    res_write            = 1'b0;
    res_data             = '0;

    case (state)
      ST_RUN: begin
        if (run && !item_end) begin
          if (merge) begin
            // extend the open island
            if (item_e > open_end) begin
              open_end_next   = item_e;
              island_len_next = item_e - open_begin;
            end
          end else begin
            if (island_open) begin
              // close island, report the gap before the new one
              length_sum_next    = length_sum + island_len;
              res_write          = 1'b1;
              res_data.kind      = gim_pkg::KIND_GAP;
              res_data.gap_begin = gim_pkg::FIELD_BITS'(open_end);
              res_data.gap_end   = gim_pkg::FIELD_BITS'(item_s);
              res_data.last      = 1'b1;
            end else if (item_s != '0) begin
              if (item_s <= gap) begin
                // short leading gap is absorbed
                drop_counter_next    = drop_counter + 2'd1;
                drop_length_sum_next = drop_length_sum + item_s;
              end else begin
                res_write          = 1'b1;
                res_data.kind      = gim_pkg::KIND_GAP;
                res_data.gap_begin = '0;
                res_data.gap_end   = gim_pkg::FIELD_BITS'(item_s);
                res_data.last      = 1'b1;
              end
            end
            // open a new island
            island_open_next    = 1'b1;
            open_begin_next     = item_s;
            open_end_next       = item_e;
            island_len_next     = item_span;
            island_counter_next = island_counter + W'(1);
          end
        end else if (run && item_end) begin
          // end request, first step: close island, tail gap or tail drop
          end_len_next   = item_len;
          tail_next      = tail_w;
          tail_drop_next = drop_now;
          if (island_open) begin
            length_sum_next = length_sum + island_len;
            if (tail_nz && !drop_now) begin
              res_write          = 1'b1;
              res_data.kind      = gim_pkg::KIND_GAP;
              res_data.gap_begin = gim_pkg::FIELD_BITS'(open_end);
              res_data.gap_end   = gim_pkg::FIELD_BITS'(item_len);
            end
          end else if (item_len != '0) begin
            res_write          = 1'b1;
            res_data.kind      = gim_pkg::KIND_GAP;
            res_data.gap_begin = '0;
            res_data.gap_end   = gim_pkg::FIELD_BITS'(item_len);
          end
          state_next = ST_END2;
        end
      end
      ST_END2: begin
        // end request, second step: summary, then clear the sequence
        if (out_space) begin
          res_write               = 1'b1;
          res_data.kind           = gim_pkg::KIND_SUMMARY;
          res_data.covered_length = gim_pkg::FIELD_BITS'(length_sum);
          res_data.island_total   = gim_pkg::FIELD_BITS'(island_counter);
          res_data.seq_length_out = gim_pkg::FIELD_BITS'(end_len);
          res_data.dropped_length = gim_pkg::FIELD_BITS'(
            drop_length_sum + (tail_drop ? tail : '0));
          res_data.dropped_total  = drop_counter + {1'b0, tail_drop};
          res_data.last           = 1'b1;
          island_open_next     = 1'b0;
          open_begin_next      = '0;
          open_end_next        = '0;
          island_len_next      = '0;
          length_sum_next      = '0;
          island_counter_next  = '0;
          drop_length_sum_next = '0;
          drop_counter_next    = '0;
          state_next           = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // per-sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_RUN;
      island_open     <= 1'b0;
      open_begin      <= '0;
      open_end        <= '0;
      island_len      <= '0;
      length_sum      <= '0;
      island_counter  <= '0;
      drop_length_sum <= '0;
      drop_counter    <= '0;
      tail_drop       <= 1'b0;
    end else begin
      state           <= state_next;
      island_open     <= island_open_next;
      open_begin      <= open_begin_next;
      open_end        <= open_end_next;
      island_len      <= island_len_next;
      length_sum      <= length_sum_next;
      island_counter  <= island_counter_next;
      drop_length_sum <= drop_length_sum_next;
      drop_counter    <= drop_counter_next;
      tail_drop       <= tail_drop_next;
    end
  end

  // end-of-sequence payload
  always_ff @(posedge clk) begin
    tail    <= tail_next;
    end_len <= end_len_next;
  end

endmodule

// ===== sv/gim_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gim_out_fifo
// Two-entry result queue that decouples the merge engine from the receiver.
// ----------------------------------------------------------------------------
module gim_out_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_write,
  input  gim_pkg::res_t res_data,
  output logic          out_space,
  input  logic          pop,
  output logic          empty,
  output gim_pkg::res_t head
);

  gim_pkg::res_t mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  logic          do_pop;

  assign empty     = (count == 2'd0);
  assign do_pop    = pop && !empty;
  // a slot frees up in the same cycle the receiver takes one
  assign out_space = (count != 2'd2) || do_pop;
  assign head      = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (res_write) mem[wr_ptr] <= res_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_write) wr_ptr <= ~wr_ptr;
      if (do_pop)    rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, res_write} - {1'b0, do_pop};
    end
  end

endmodule

// ===== sv/gap_interval_merger.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_interval_merger
// Merges sorted annotation intervals into islands and reports the gaps.
// ----------------------------------------------------------------------------
// Input side is a queue: a request is taken when push is high and full is
// low. opcode 0 carries an interval (ann_start, ann_stop, 1-based), opcode 1
// ends the sequence (seq_length). Results come out of a queue: while empty
// is low the oldest result is on the ports, pop takes it. last marks the
// final result of an input request. max_gap is written with max_gap_write
// while the block is idle: a rule for the user, not enforced by the block.
// A result is visible the cycle after the merge engine takes the item; an
// input request first passes the decoded queue, and the summary of an end
// request follows its tail gap slot. Throughput: one interval per cycle
// while the result queue has space, set by the combinational merge compare
// in the merge engine; an end request takes two engine steps (tail gap,
// then summary). A two-entry decoded queue sits in front of the engine and
// a two-entry result queue behind it, so a stalled receiver first fills the
// result queue, then the decoded queue, and then full rises.
// Reset clears both queues, the sequence state and max_gap.
// ----------------------------------------------------------------------------
module gap_interval_merger #(
  parameter int COORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        max_gap_write,
  input  logic [31:0] max_gap,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [31:0] ann_start,
  input  logic [31:0] ann_stop,
  input  logic [31:0] seq_length,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [31:0] gap_begin,
  output logic [31:0] gap_end,
  output logic [31:0] covered_length,
  output logic [31:0] island_total,
  output logic [31:0] seq_length_out,
  output logic [31:0] dropped_length,
  output logic [1:0]  dropped_total,
  output logic        last
);

  localparam int W = COORD_BITS;

  logic [31:0]   gap_limit;
  logic          item_valid, item_take, item_end;
  logic [W-1:0]  item_s, item_e, item_span, item_len;
  logic          out_space, res_write;
  gim_pkg::res_t res_data, head;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= '0;
    end else if (max_gap_write) begin
      gap_limit <= max_gap;
    end
  end

  gim_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .ann_start  (ann_start),
    .ann_stop   (ann_stop),
    .seq_length (seq_length),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item_end   (item_end),
    .item_s     (item_s),
    .item_e     (item_e),
    .item_span  (item_span),
    .item_len   (item_len)
  );

  gim_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .gap        (W'(gap_limit)),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item_end   (item_end),
    .item_s     (item_s),
    .item_e     (item_e),
    .item_span  (item_span),
    .item_len   (item_len),
    .out_space  (out_space),
    .res_write  (res_write),
    .res_data   (res_data)
  );

  gim_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .res_write (res_write),
    .res_data  (res_data),
    .out_space (out_space),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  // result ports
  assign kind           = head.kind;
  assign gap_begin      = head.gap_begin;
  assign gap_end        = head.gap_end;
  assign covered_length = head.covered_length;
  assign island_total   = head.island_total;
  assign seq_length_out = head.seq_length_out;
  assign dropped_length = head.dropped_length;
  assign dropped_total  = head.dropped_total;
  assign last           = head.last;

endmodule

// ===== tb/sv/gap_interval_merger_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_interval_merger_tb
// Self-checking bench for the gap interval merger. A scoreboard class keeps
// its own copy of the island state and max_gap. It predicts every gap and
// summary request for each accepted input and checks the results in order.
// Stimulus is a directed set of corner cases, then phases of sorted
// sequences mixed with noise, each phase under a new max_gap. Random idling
// is applied on both sides, and one long receiver stall backs up the input.
// ----------------------------------------------------------------------------
module gap_interval_merger_tb;

  localparam int  HALF_PERIOD  = 6;
  localparam int  RESET_CYCLES = 6;
  localparam int  RANDOM_ITEMS = 2000;
  localparam int  PHASE_ITEMS  = 150;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  SETTLE       = 10;
  localparam int  REPORT_MAX   = 10;

  // island tracker and expected result store
  class merge_scoreboard;
    logic [31:0]   gap_limit;
    bit            island_open;
    logic [31:0]   open_begin;
    logic [31:0]   open_end;
    logic [31:0]   length_sum;
    logic [31:0]   island_count;
    logic [31:0]   drop_sum;
    logic [1:0]    drop_count;
    gim_pkg::res_t expected_q[$];
    int            mismatches;
    int            results_seen;
    int            summaries_seen;

    function new();
      gap_limit      = '0;
      mismatches     = 0;
      results_seen   = 0;
      summaries_seen = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      island_open  = 0;
      open_begin   = '0;
      open_end     = '0;
      length_sum   = '0;
      island_count = '0;
      drop_sum     = '0;
      drop_count   = '0;
    endfunction

    function void set_gap(logic [31:0] value);
      gap_limit = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_gap(logic [31:0] gb, logic [31:0] ge);
      gim_pkg::res_t r;
      r           = '0;
      r.kind      = gim_pkg::KIND_GAP;
      r.gap_begin = gb;
      r.gap_end   = ge;
      expected_q.push_back(r);
    endfunction

    // predict the results of one accepted input request
    function void note_request(logic op, logic [31:0] a_start, logic [31:0] a_stop,
                               logic [31:0] len);
      logic [31:0]   s;
      logic [31:0]   e;
      logic [31:0]   tail;
      gim_pkg::res_t r;
      int            before_cnt;
      before_cnt = expected_q.size();
      if (op == gim_pkg::OP_INTERVAL) begin
        s = (a_start == 0) ? 32'd0 : a_start - 32'd1;
        e = a_stop;
        if (e < s) e = s;
        // close enough: extend the open island
        if (island_open && (s <= open_end || s - open_end <= gap_limit)) begin
          if (e > open_end) open_end = e;
          return;
        end
        if (island_open) begin
          length_sum = length_sum + (open_end - open_begin);
          add_gap(open_end, s);
        end else if (s != 0) begin
          // leading gap, dropped when short
          if (s <= gap_limit) begin
            drop_count = drop_count + 2'd1;
            drop_sum   = drop_sum + s;
          end else begin
            add_gap(32'd0, s);
          end
        end
        island_open  = 1;
        open_begin   = s;
        open_end     = e;
        island_count = island_count + 32'd1;
      end else begin
        if (island_open) begin
          tail       = (len > open_end) ? len - open_end : 32'd0;
          length_sum = length_sum + (open_end - open_begin);
          if (tail != 0 && tail <= gap_limit) begin
            drop_count = drop_count + 2'd1;
            drop_sum   = drop_sum + tail;
          end else if (tail != 0) begin
            add_gap(open_end, len);
          end
        end else if (len != 0) begin
          add_gap(32'd0, len);
        end
        r                = '0;
        r.kind           = gim_pkg::KIND_SUMMARY;
        r.covered_length = length_sum;
        r.island_total   = island_count;
        r.seq_length_out = len;
        r.dropped_length = drop_sum;
        r.dropped_total  = drop_count;
        expected_q.push_back(r);
        clear_sequence();
      end
      if (expected_q.size() > before_cnt) begin
        r      = expected_q.pop_back();
        r.last = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    // compare one popped result with the oldest expectation
    function void check_result(gim_pkg::res_t got);
      gim_pkg::res_t want;
      bit            bad;
      results_seen++;
      if (got.kind === gim_pkg::KIND_SUMMARY) summaries_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result %0d: kind=%0d gap=[%0h,%0h) last=%0d",
                   results_seen, got.kind, got.gap_begin, got.gap_end, got.last);
        return;
      end
      want = expected_q.pop_front();
      bad  = 0;
      if (got.kind           !== want.kind)           bad = 1;
      if (got.gap_begin      !== want.gap_begin)      bad = 1;
      if (got.gap_end        !== want.gap_end)        bad = 1;
      if (got.covered_length !== want.covered_length) bad = 1;
      if (got.island_total   !== want.island_total)   bad = 1;
      if (got.seq_length_out !== want.seq_length_out) bad = 1;
      if (got.dropped_length !== want.dropped_length) bad = 1;
      if (got.dropped_total  !== want.dropped_total)  bad = 1;
      if (got.last           !== want.last)           bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("mismatch on result %0d", results_seen);
          $display("  exp kind=%0d gap=[%0h,%0h) cov=%0h isl=%0h len=%0h drop=%0h/%0d last=%0d",
                   want.kind, want.gap_begin, want.gap_end, want.covered_length,
                   want.island_total, want.seq_length_out, want.dropped_length,
                   want.dropped_total, want.last);
          $display("  act kind=%0d gap=[%0h,%0h) cov=%0h isl=%0h len=%0h drop=%0h/%0d last=%0d",
                   got.kind, got.gap_begin, got.gap_end, got.covered_length,
                   got.island_total, got.seq_length_out, got.dropped_length,
                   got.dropped_total, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        max_gap_write = 1'b0;
  logic [31:0] max_gap = '0;
  logic        push = 1'b0;
  logic        full;
  logic        opcode = gim_pkg::OP_INTERVAL;
  logic [31:0] ann_start = '0;
  logic [31:0] ann_stop = '0;
  logic [31:0] seq_length = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind;
  logic [31:0] gap_begin;
  logic [31:0] gap_end;
  logic [31:0] covered_length;
  logic [31:0] island_total;
  logic [31:0] seq_length_out;
  logic [31:0] dropped_length;
  logic [1:0]  dropped_total;
  logic        last;

  merge_scoreboard sb = new();

  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  bit hold_req  = 1'b0;
  int items_sent;
  int settings_used;
  int full_stalls;

  gap_interval_merger DUT (
    .clk            (clk),
    .rst            (rst),
    .max_gap_write  (max_gap_write),
    .max_gap        (max_gap),
    .push           (push),
    .full           (full),
    .opcode         (opcode),
    .ann_start      (ann_start),
    .ann_stop       (ann_stop),
    .seq_length     (seq_length),
    .empty          (empty),
    .pop            (pop),
    .kind           (kind),
    .gap_begin      (gap_begin),
    .gap_end        (gap_end),
    .covered_length (covered_length),
    .island_total   (island_total),
    .seq_length_out (seq_length_out),
    .dropped_length (dropped_length),
    .dropped_total  (dropped_total),
    .last           (last)
  );

  // clock
  always #(HALF_PERIOD) clk = ~clk;

  // watchdog
  initial begin
    #12_000_000;
    $display("gap_interval_merger verification failed");
    $finish;
  end

  // handshake monitor: note accepted requests, check popped results
  always @(posedge clk) begin
    gim_pkg::res_t got;
    if (!rst) begin
      if (push && full === 1'b0)
        sb.note_request(opcode, ann_start, ann_stop, seq_length);
      if (push && full === 1'b1)
        full_stalls++;
      if (pop && empty === 1'b0) begin
        got.kind           = kind;
        got.gap_begin      = gap_begin;
        got.gap_end        = gap_end;
        got.covered_length = covered_length;
        got.island_total   = island_total;
        got.seq_length_out = seq_length_out;
        got.dropped_length = dropped_length;
        got.dropped_total  = dropped_total;
        got.last           = last;
        sb.check_result(got);
      end
    end
  end

  // receiver: random pop bursts, one long hold-off on request
  initial begin
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic [31:0] clamp32(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // distance from an island end, spread around the bridging limit
  function automatic longint unsigned gap_pick(longint unsigned g);
    case ($urandom_range(0, 6))
      0: return 0;
      1: return (g == 0) ? 0 : $urandom_range(1, (g > 20) ? 20 : int'(g));
      2: return g;
      3: return g + 1;
      4: return g + $urandom_range(2, 40);
      5: return $urandom_range(0, 1000);
      default: return (g > 40) ? g - $urandom_range(0, 40) : $urandom_range(0, int'(g));
    endcase
  endfunction

  function automatic logic [31:0] word_pick();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 200);
      default: return $urandom;
    endcase
  endfunction

  // offer one request and hold it until accepted
  task automatic send_item(logic op, logic [31:0] a_start, logic [31:0] a_stop,
                           logic [31:0] len);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    push       <= 1'b1;
    opcode     <= op;
    ann_start  <= a_start;
    ann_stop   <= a_stop;
    seq_length <= len;
    do @(posedge clk); while (full !== 1'b0);
    items_sent++;
  endtask

  // wait until every expected result has come and the engine is quiet
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_max_gap(logic [31:0] value);
    max_gap_write <= 1'b1;
    max_gap       <= value;
    @(posedge clk);
    sb.set_gap(value);
    max_gap_write <= 1'b0;
    settings_used++;
  endtask

  // one sorted sequence of n intervals closed by an end request
  task automatic run_sequence(int n);
    longint unsigned g;
    longint unsigned s;
    longint unsigned e;
    longint unsigned cur_end;
    longint unsigned len;
    logic [31:0]     a_start;
    logic [31:0]     a_stop;
    g       = sb.gap_limit;
    cur_end = 0;
    s       = gap_pick(g);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        if ($urandom_range(0, 3) == 0)
          s = (cur_end > 30) ? cur_end - $urandom_range(0, 30) : $urandom_range(0, int'(cur_end));
        else
          s = cur_end + gap_pick(g);
      end
      e = s + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 100000) : $urandom_range(0, 60));
      a_start = clamp32(s + 1);
      a_stop  = clamp32(e);
      // occasional start of zero or stop before start
      if (s == 0 && $urandom_range(0, 1) == 0) a_start = 32'd0;
      if ($urandom_range(0, 15) == 0 && a_start > 1) a_stop = $urandom_range(0, 30) % a_start;
      send_item(gim_pkg::OP_INTERVAL, a_start, a_stop, $urandom);
      if (i == 0 || clamp32(e) > cur_end) cur_end = clamp32(e);
    end
    case ($urandom_range(0, 9))
      0: len = 0;
      1, 2: len = (cur_end > 20) ? cur_end - $urandom_range(0, 20) : $urandom_range(0, int'(cur_end));
      default: len = cur_end + gap_pick(g);
    endcase
    send_item(gim_pkg::OP_END, $urandom, $urandom, clamp32(len));
  endtask

  function automatic logic [31:0] setting_pick(int ph);
    case (ph)
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1;
      default: begin
        case ($urandom_range(0, 7))
          0: return 32'd0;
          1: return 32'd1;
          2, 3: return $urandom_range(2, 20);
          4, 5: return $urandom_range(21, 2000);
          6: return 32'hFFFF_FFFF - $urandom_range(0, 50);
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // main stimulus
  initial begin
    int target;
    int ph;
    int k;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed cases, max_gap at its reset value of zero
    send_item(gim_pkg::OP_END, 32'd0, 32'd0, 32'd0);         // empty sequence, no gap
    send_item(gim_pkg::OP_END, 32'd0, 32'd0, 32'd7);         // whole sequence is a gap
    send_item(gim_pkg::OP_INTERVAL, 32'd0, 32'd0, 32'd0);    // start of zero
    send_item(gim_pkg::OP_INTERVAL, 32'd3, 32'd2, 32'd0);    // stop before start
    send_item(gim_pkg::OP_INTERVAL, 32'd2, 32'd9, 32'hFFFF_FFFF); // start before open island
    send_item(gim_pkg::OP_INTERVAL, 32'd12, 32'd20, 32'd0);
    send_item(gim_pkg::OP_END, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd15); // island past end
    send_item(gim_pkg::OP_INTERVAL, 32'd1, 32'hFFFF_FFFF, 32'd0);
    send_item(gim_pkg::OP_END, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(gim_pkg::OP_INTERVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_item(gim_pkg::OP_END, 32'd0, 32'd0, 32'd1);
    drain();
    write_max_gap(32'd10);
    send_item(gim_pkg::OP_INTERVAL, 32'd5, 32'd20, 32'd0);   // short leading gap dropped
    send_item(gim_pkg::OP_INTERVAL, 32'd31, 32'd40, 32'd0);  // gap equal to limit bridged
    send_item(gim_pkg::OP_INTERVAL, 32'd52, 32'd60, 32'd0);  // one past limit splits
    send_item(gim_pkg::OP_END, 32'd0, 32'd0, 32'd65);        // short tail dropped
    send_item(gim_pkg::OP_INTERVAL, 32'd20, 32'd30, 32'd0);  // long leading gap
    send_item(gim_pkg::OP_END, 32'd0, 32'd0, 32'd100);       // long tail gap
    drain();
    write_max_gap(32'hFFFF_FFFF);
    send_item(gim_pkg::OP_INTERVAL, 32'hFFFF_FFFF, 32'd5, 32'd0);
    send_item(gim_pkg::OP_END, 32'd0, 32'd0, 32'd0);
    send_item(gim_pkg::OP_INTERVAL, 32'd1, 32'd1, 32'd0);
    send_item(gim_pkg::OP_INTERVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_item(gim_pkg::OP_END, 32'd0, 32'd0, 32'hFFFF_FFFF);

    // random phases, each under a new max_gap
    target = items_sent + RANDOM_ITEMS;
    ph     = 0;
    while (items_sent < target) begin
      drain();
      write_max_gap(setting_pick(ph));
      if (items_sent >= target - 300) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end else begin
        src_idle  = (ph % 4 != 1);
        sink_idle = (ph % 4 != 1);
      end
      // back up the block behind a long receiver stall
      if (ph == 2) begin
        src_idle = 1'b0;
        hold_req = 1'b1;
      end
      k = items_sent + PHASE_ITEMS;
      while (items_sent < k) begin
        if ($urandom_range(0, 4) == 0)
          send_item(($urandom_range(0, 3) == 0) ? gim_pkg::OP_END : gim_pkg::OP_INTERVAL,
                    word_pick(), word_pick(), word_pick());
        else
          run_sequence($urandom_range(0, 8));
      end
      ph++;
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d requests under %0d max_gap settings, %0d results (%0d summaries)",
             items_sent, settings_used, sb.results_seen, sb.summaries_seen);
    $display("input held off by full for %0d cycles, %0d results mismatched",
             full_stalls, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("gap_interval_merger verification clean");
    else
      $display("gap_interval_merger verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/gim_pkg.sv
sv/gim_front.sv
sv/gim_back.sv
sv/gim_out_fifo.sv
sv/gap_interval_merger.sv
tb/sv/gap_interval_merger_tb.sv
